[sv/rrcd_pkg.sv]
package rrcd_pkg;

   localparam int TimeWidth = 48;
   localparam logic [TimeWidth-1:0] Max48 = '1;

   typedef enum logic [1:0] {
      OP_START    = 2'd0,
      OP_REQUEST  = 2'd1,
      OP_COMPLETE = 2'd2,
      OP_STATS    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_REGION_COUNT = 3'd0,
      CSR_CHUNK_SIZE   = 3'd1,
      CSR_REGION_SIZE  = 3'd2,
      CSR_BASE_OFFSET  = 3'd3,
      CSR_PER_FILE     = 3'd4,
      CSR_READ_MODE    = 3'd5
   } csr_type;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_MOD    = 8'b0000_0010,
      ST_FILL   = 8'b0000_0100,
      ST_SCAN   = 8'b0000_1000,
      ST_CPL_RD = 8'b0001_0000,
      ST_CPL_WR = 8'b0010_0000,
      ST_STAT   = 8'b0100_0000,
      ST_DIV    = 8'b1000_0000
   } state_type;

   function automatic logic [TimeWidth-1:0] sat48(input logic [TimeWidth:0] v);
      sat48 = v[TimeWidth] ? Max48 : v[TimeWidth-1:0];
   endfunction

endpackage

[sv/rrcd_ram.sv]
module rrcd_ram #(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(Depth>1?Depth:2)-1:0] wr_addr,
   input  logic [Width-1:0]               wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(Depth>1?Depth:2)-1:0] rd_addr,
   output logic [Width-1:0]               rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

[sv/round_robin_region_chunk_dispatcher.sv]
// Round-robin chunk dispatcher over a table of up to MAX_REGIONS regions held in one
// synchronous RAM (offset, limit, time per entry). Raise start with an operation while
// busy is low; exactly one rsp_valid pulse follows per request and cannot be stalled.
// Start writes one table entry per cycle. A chunk request first reduces the scan
// pointer modulo n by repeated subtraction. It then reads one entry per cycle from the
// pointer and checks each in the cycle after its read. Complete is a read-modify-write,
// or a response without a table access when the region is out of range. Statistics
// reads every entry and then divides the 56-bit sum by n one quotient bit per cycle.
// The RAM read port sets the one-entry-per-cycle pace.
module round_robin_region_chunk_dispatcher
   import rrcd_pkg::*;
#(
   parameter int MAX_REGIONS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [6:0]  req_done_region,
   input  logic [31:0] req_elapsed_time,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic [6:0]  rsp_issued_region,
   output logic [6:0]  rsp_file_id,
   output logic [47:0] rsp_chunk_offset,
   output logic [31:0] rsp_byte_count,
   output logic        rsp_is_read,
   output logic [47:0] rsp_lowest_time,
   output logic [47:0] rsp_highest_time,
   output logic [47:0] rsp_average_time,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [40:0] csr_data
);
   localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam int SW = TimeWidth + CW;
   localparam int DW = 3 * TimeWidth;
   localparam int DCW = $clog2(SW + 1);

   logic [7:0]  region_count_ff;
   logic [31:0] chunk_size_ff;
   logic [40:0] region_size_ff;
   logic [40:0] base_offset_ff;
   logic        per_file_ff;
   logic        read_mode_ff;
   logic        latched_ff, latched_in;

   state_type state_ff, state_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] modv_ff, modv_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] sidx_ff, sidx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pidx_ff, pidx_in;
   logic          plast_ff, plast_in;
   logic [TimeWidth-1:0] acc_ff, acc_in;
   logic [TimeWidth-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [CW:0]   rem_ff, rem_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [31:0]   elapsed_ff, elapsed_in;
   logic [AW-1:0] done_ff, done_in;

   logic        rsp_valid_in, rsp_found_in, rsp_is_read_in;
   logic [6:0]  rsp_region_in, rsp_file_in;
   logic [47:0] rsp_offset_in, rsp_lo_in, rsp_hi_in, rsp_avg_in;
   logic [31:0] rsp_count_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [DW-1:0] wr_data, rd_data;

   logic [CW-1:0] n;
   logic [TimeWidth-1:0] r_off, r_lim, r_time;
   logic [TimeWidth:0]   next_off;
   logic [TimeWidth-1:0] fill_start;
   logic [CW:0]          rem_sh;
   logic                 more;

   always_comb begin
      if (region_count_ff == 8'd0) begin
         n = CW'(1);
      end else if (32'(region_count_ff) > 32'(MAX_REGIONS)) begin
         n = CW'(MAX_REGIONS);
      end else begin
         n = CW'(region_count_ff);
      end
   end

   assign r_off    = rd_data[DW-1 -: TimeWidth];
   assign r_lim    = rd_data[2*TimeWidth-1 -: TimeWidth];
   assign r_time   = rd_data[TimeWidth-1:0];
   assign next_off = {1'b0, r_off} + (TimeWidth+1)'(chunk_size_ff);
   assign fill_start = latched_ff ? TimeWidth'(base_offset_ff) : acc_ff;
   assign rem_sh   = {rem_ff[CW-1:0], sum_ff[SW-1]};
   assign more     = cnt_ff < n;
   assign busy     = (state_ff != ST_IDLE);

   rrcd_ram #(.Width(DW), .Depth(MAX_REGIONS)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      latched_in = latched_ff;
      ptr_in     = ptr_ff;
      modv_in    = modv_ff;
      idx_in     = idx_ff;
      sidx_in    = sidx_ff;
      cnt_in     = cnt_ff;
      pend_in    = 1'b0;
      pidx_in    = idx_ff;
      plast_in   = (cnt_ff == n - CW'(1));
      acc_in     = acc_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      sum_in     = sum_ff;
      rem_in     = rem_ff;
      dcnt_in    = dcnt_ff;
      elapsed_in = elapsed_ff;
      done_in    = done_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = idx_ff;
      rsp_valid_in   = 1'b0;
      rsp_found_in   = 1'b0;
      rsp_region_in  = '0;
      rsp_file_in    = '0;
      rsp_offset_in  = '0;
      rsp_count_in   = '0;
      rsp_is_read_in = 1'b0;
      rsp_lo_in      = '0;
      rsp_hi_in      = '0;
      rsp_avg_in     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in = '0;
               cnt_in = '0;
               case (op_type'(req_operation))
                  OP_START: begin
                     latched_in = per_file_ff;
                     acc_in     = '0;
                     state_in   = ST_FILL;
                  end
                  OP_REQUEST: begin
                     modv_in  = CW'(ptr_ff);
                     state_in = ST_MOD;
                  end
                  OP_COMPLETE: begin
                     if (32'(req_done_region) < 32'(n)) begin
                        done_in    = AW'(req_done_region);
                        elapsed_in = req_elapsed_time;
                        state_in   = ST_CPL_RD;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     sum_in   = '0;
                     state_in = ST_STAT;
                  end
               endcase
            end
         end
         ST_MOD: begin
            if (modv_ff >= n) begin
               modv_in = modv_ff - n;
            end else begin
               sidx_in  = AW'(modv_ff);
               idx_in   = AW'(modv_ff);
               state_in = ST_SCAN;
            end
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_data = {fill_start,
                       sat48({1'b0, fill_start} + (TimeWidth+1)'(region_size_ff)),
                       {TimeWidth{1'b0}}};
            acc_in  = sat48({1'b0, acc_ff} + (TimeWidth+1)'(base_offset_ff));
            idx_in  = idx_ff + AW'(1);
            if (CW'(idx_ff) == n - CW'(1)) begin
               ptr_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (pend_ff && next_off <= {1'b0, r_lim}) begin
               wr_en          = 1'b1;
               wr_addr        = pidx_ff;
               wr_data        = {sat48(next_off), r_lim, r_time};
               rsp_valid_in   = 1'b1;
               rsp_found_in   = 1'b1;
               rsp_region_in  = 7'(pidx_ff);
               rsp_file_in    = latched_ff ? 7'(pidx_ff) : 7'd0;
               rsp_offset_in  = r_off;
               rsp_count_in   = chunk_size_ff;
               rsp_is_read_in = read_mode_ff;
               ptr_in = (CW'(sidx_ff) == n - CW'(1)) ? '0 : sidx_ff + AW'(1);
               state_in = ST_IDLE;
            end else if (pend_ff && plast_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (more) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               cnt_in  = cnt_ff + CW'(1);
               idx_in  = (CW'(idx_ff) == n - CW'(1)) ? '0 : idx_ff + AW'(1);
            end
         end
         ST_CPL_RD: begin
            rd_en    = 1'b1;
            rd_addr  = done_ff;
            state_in = ST_CPL_WR;
         end
         ST_CPL_WR: begin
            wr_en        = 1'b1;
            wr_addr      = done_ff;
            wr_data      = {r_off, r_lim,
                            sat48({1'b0, r_time} + (TimeWidth+1)'(elapsed_ff))};
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_STAT: begin
            if (pend_ff) begin
               sum_in = sum_ff + SW'(r_time);
               if (CW'(pidx_ff) == CW'(0) || r_time < lo_ff) begin
                  lo_in = r_time;
               end
               if (CW'(pidx_ff) == CW'(0) || r_time > hi_ff) begin
                  hi_in = r_time;
               end
            end
            if (pend_ff && plast_ff) begin
               rem_in   = '0;
               dcnt_in  = '0;
               state_in = ST_DIV;
            end else if (more) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               cnt_in  = cnt_ff + CW'(1);
               idx_in  = idx_ff + AW'(1);
            end
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, n}) begin
               rem_in = rem_sh - {1'b0, n};
               sum_in = {sum_ff[SW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               sum_in = {sum_ff[SW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + DCW'(1);
            if (dcnt_ff == DCW'(SW - 1)) begin
               rsp_valid_in = 1'b1;
               rsp_lo_in    = lo_ff;
               rsp_hi_in    = hi_ff;
               rsp_avg_in   = sum_in[TimeWidth-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         ptr_ff          <= '0;
         pend_ff         <= 1'b0;
         latched_ff      <= 1'b1;
         rsp_valid       <= 1'b0;
         region_count_ff <= 8'd1;
         chunk_size_ff   <= 32'd524288;
         region_size_ff  <= 41'd8388608;
         base_offset_ff  <= 41'd8388608;
         per_file_ff     <= 1'b1;
         read_mode_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ptr_ff     <= ptr_in;
         pend_ff    <= pend_in;
         latched_ff <= latched_in;
         rsp_valid  <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_type'(csr_index))
               CSR_REGION_COUNT: region_count_ff <= csr_data[7:0];
               CSR_CHUNK_SIZE:   chunk_size_ff   <= csr_data[31:0];
               CSR_REGION_SIZE:  region_size_ff  <= csr_data;
               CSR_BASE_OFFSET:  base_offset_ff  <= csr_data;
               CSR_PER_FILE:     per_file_ff     <= csr_data[0];
               CSR_READ_MODE:    read_mode_ff    <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      modv_ff    <= modv_in;
      idx_ff     <= idx_in;
      sidx_ff    <= sidx_in;
      cnt_ff     <= cnt_in;
      pidx_ff    <= pidx_in;
      plast_ff   <= plast_in;
      acc_ff     <= acc_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      sum_ff     <= sum_in;
      rem_ff     <= rem_in;
      dcnt_ff    <= dcnt_in;
      elapsed_ff <= elapsed_in;
      done_ff    <= done_in;
      rsp_found         <= rsp_found_in;
      rsp_issued_region <= rsp_region_in;
      rsp_file_id       <= rsp_file_in;
      rsp_chunk_offset  <= rsp_offset_in;
      rsp_byte_count    <= rsp_count_in;
      rsp_is_read       <= rsp_is_read_in;
      rsp_lowest_time   <= rsp_lo_in;
      rsp_highest_time  <= rsp_hi_in;
      rsp_average_time  <= rsp_avg_in;
   end
endmodule
